// File: design/gfcd_pkg.sv
// Shared types and constants for the grid frontier cell detector.
// No dependencies; the frontier interface, the result queue and the top level import this package.
package gfcd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Size registers are 11 bits wide so that they can hold the full maximum.
  localparam int SIZE_W      = 11;
  localparam int CFG_DATA_W  = SIZE_W;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_UNKNOWN_CODE = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_FREE_LIMIT   = CFG_INDEX_W'(3);

  localparam logic [SIZE_W-1:0] GRID_WIDTH_RST   = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST  = SIZE_W'(64);
  localparam logic [7:0]        UNKNOWN_CODE_RST = 8'hFF;
  localparam logic [6:0]        FREE_LIMIT_RST   = 7'd50;

  // Per-cell class bits.
  typedef struct packed {
    logic free;
    logic unknown;
  } cls_t;

  // One line store entry: class of row y-1 and of row y-2 at one column.
  typedef struct packed {
    cls_t prev;
    cls_t older;
  } line_entry_t;

  localparam int LINE_W = $bits(line_entry_t);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } result_t;

  // One candidate result from a cell, pushed toward the result queue.
  typedef struct packed {
    logic    valid;
    result_t res;
  } cand_t;

  localparam int RES_MAX    = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
  // Room for the cell in flight and the one entering.
  localparam logic [FIFO_CNT_W-1:0] ROOM_LIMIT = FIFO_CNT_W'(FIFO_DEPTH - 2 * RES_MAX);

endpackage

// File: design/gfcd_cell_if.sv
// Input channel of the frontier detector: one occupancy cell per transaction.
// Stand-alone interface, no package needed.
interface gfcd_cell_if ();
  logic              valid;
  logic              ready;
  logic signed [7:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

// File: design/gfcd_frontier_if.sv
// Output channel of the frontier detector: one frontier coordinate per transaction.
// Depends on gfcd_pkg for the coordinate widths.
interface gfcd_frontier_if import gfcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] frontier_col;
  logic [ROW_W-1:0] frontier_row;
  logic             last_of_run;

  modport source (output valid, output frontier_col, output frontier_row,
                  output last_of_run, input ready);
  modport sink   (input valid, input frontier_col, input frontier_row,
                  input last_of_run, output ready);
endinterface

// File: design/gfcd_ram.sv
// Generic RAM: one write port and two read ports with registered read data.
// Old data is returned when a read hits the address written in the same cycle.
module gfcd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: design/gfcd_result_fifo.sv
// Result queue: takes up to RES_MAX results per cycle, in order, and drives
// the output channel one result per transaction. Depends on gfcd_pkg.
module gfcd_result_fifo import gfcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cand_t [RES_MAX-1:0]   push,
  gfcd_frontier_if.source       out,
  output logic                  has_room
);

  result_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_CNT_W-1:0]   count;
  logic [FIFO_PTR_W-1:0]   slot [RES_MAX];
  logic [FIFO_CNT_W-1:0]   n_push;
  logic                    pop;

  // Pack valid candidates into consecutive slots.
  always_comb begin
    n_push = '0;
    for (int i = 0; i < RES_MAX; i++) begin
      slot[i] = wr_ptr + n_push[FIFO_PTR_W-1:0];
      n_push  = n_push + FIFO_CNT_W'(push[i].valid);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (push[i].valid) begin
        mem[slot[i]] <= push[i].res;
      end
    end
  end

  assign pop = out.valid && out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[FIFO_PTR_W-1:0];
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count + n_push - FIFO_CNT_W'(pop);
    end
  end

  assign out.valid        = (count != '0);
  assign out.frontier_col = mem[rd_ptr].col;
  assign out.frontier_row = mem[rd_ptr].row;
  assign out.last_of_run  = mem[rd_ptr].last;
  assign has_room         = (count <= ROOM_LIMIT);

endmodule

// File: design/grid_frontier_cell_detector.sv
// Top level of the grid frontier cell detector, built from gfcd_ram and
// gfcd_result_fifo; depends on gfcd_pkg and the two channel interfaces.
//
// Takes occupancy cells in raster order, one per clock, and reports each
// unknown cell with a free 4-neighbor as soon as all its neighbors are in:
// the cell above on the arrival of the cell below it, last-row cells on the
// arrival of their right neighbor, and the final cell of the frame at once.
// A cell transaction causes zero to three results; the last one of a group
// carries last_of_run. Each cell is held in the input register, where a
// line-store read (one 4-bit RAM holding the classes of rows y-1 and y-2,
// two read ports, one write port) and the neighbor logic produce its
// results, which enter an 8-entry result queue at the next edge. New cells
// are taken every cycle while the queue holds at most two results, so the
// sustained rate is one cell per clock, bounded by the output channel's one
// result per clock where results come faster (up to two per cell in the
// last row, three for its final cell). Column and row counters wrap at frame
// end. The line store has no reset and needs no clearing pass: every entry
// is written before it is read within a frame. Write configuration only
// while the block is idle.
module grid_frontier_cell_detector import gfcd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   write_enable,
  input  logic [CFG_INDEX_W-1:0] reg_index,
  input  logic [CFG_DATA_W-1:0]  write_data,
  gfcd_cell_if.sink              cells,
  gfcd_frontier_if.source        frontiers
);

  typedef struct packed {
    logic signed [7:0] value;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic              x_ge1;
    logic              x_ge2;
    logic              y_ge1;
    logic              y_ge2;
    logic              has_right;
    logic              last_row;
    logic              last_col;
    logic              fwd0;
    logic              fwd1;
  } stage_t;

  // Configuration registers
  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic [7:0]        unknown_code;
  logic [6:0]        free_limit;

  // Position and neighbor state
  logic [COL_W-1:0]  column_counter;
  logic [ROW_W-1:0]  row_counter;
  cls_t              left_cls;
  cls_t              last_c;
  cls_t              last2_c;

  // Input register
  logic              s1_valid;
  stage_t            s1;
  line_entry_t       fwd_data;

  // Accept-side logic
  logic              accept;
  logic              has_room;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic [COL_W-1:0]  x_eff;
  logic [ROW_W-1:0]  y_eff;
  logic [SIZE_W-1:0] x_plus;
  logic [SIZE_W-1:0] y_plus;
  logic [COL_W-1:0]  rd_addr0;
  logic [COL_W-1:0]  rd_addr1;
  logic              last_col;
  logic              last_row;
  logic [COL_W-1:0]  column_counter_next;
  logic [ROW_W-1:0]  row_counter_next;
  stage_t            s1_next;

  // Evaluation-side logic
  line_entry_t       rd0;
  line_entry_t       rd1;
  line_entry_t       entry0;
  line_entry_t       entry1;
  line_entry_t       wr_entry;
  cls_t              c;
  cls_t              self_cls;
  cls_t              nb0;
  cls_t              nb1;
  cls_t              nb2;
  logic              v0;
  logic              v1;
  logic              v2;
  cand_t [RES_MAX-1:0] cand;

  // ---------------------------------------------------------------------
  // Configuration: write-only register file
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= GRID_WIDTH_RST;
      grid_height  <= GRID_HEIGHT_RST;
      unknown_code <= UNKNOWN_CODE_RST;
      free_limit   <= FREE_LIMIT_RST;
    end else if (write_enable) begin
      case (reg_index)
        REG_GRID_WIDTH:   grid_width   <= write_data;
        REG_GRID_HEIGHT:  grid_height  <= write_data;
        REG_UNKNOWN_CODE: unknown_code <= write_data[7:0];
        REG_FREE_LIMIT:   free_limit   <= write_data[6:0];
        default: ;
      endcase
    end
  end

  // Clamp the sizes in use: zero acts as one, anything above the maximum
  // acts as the maximum.
  always_comb begin
    if (grid_width == '0) begin
      w_eff = SIZE_W'(1);
    end else if (grid_width > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height == '0) begin
      h_eff = SIZE_W'(1);
    end else if (grid_height > SIZE_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
  end

  // ---------------------------------------------------------------------
  // Accept side: position of the incoming cell, line-store read addresses
  // ---------------------------------------------------------------------
  assign accept      = cells.valid && cells.ready;
  assign cells.ready = has_room;

  always_comb begin
    // Restart a counter that a size change left out of range.
    x_eff    = (SIZE_W'(column_counter) >= w_eff) ? '0 : column_counter;
    y_eff    = (SIZE_W'(row_counter) >= h_eff) ? '0 : row_counter;
    x_plus   = SIZE_W'(x_eff) + SIZE_W'(1);
    y_plus   = SIZE_W'(y_eff) + SIZE_W'(1);
    last_col = (x_plus == w_eff);
    last_row = (y_plus == h_eff);
    rd_addr0 = x_eff;
    rd_addr1 = x_plus[COL_W-1:0];

    // Advance raster position; wrap both counters at frame end.
    column_counter_next = last_col ? '0 : x_plus[COL_W-1:0];
    if (last_col) begin
      row_counter_next = last_row ? '0 : y_plus[ROW_W-1:0];
    end else begin
      row_counter_next = y_eff;
    end

    s1_next.value     = cells.cell_value;
    s1_next.x         = x_eff;
    s1_next.y         = y_eff;
    s1_next.x_ge1     = (x_eff != '0);
    s1_next.x_ge2     = (x_eff > COL_W'(1));
    s1_next.y_ge1     = (y_eff != '0);
    s1_next.y_ge2     = (y_eff > ROW_W'(1));
    s1_next.has_right = (x_plus < w_eff);
    s1_next.last_row  = last_row;
    s1_next.last_col  = last_col;
    // The cell in the input register writes its column at this same edge:
    // forward that entry instead of the stale read data.
    s1_next.fwd0      = s1_valid && (rd_addr0 == s1.x);
    s1_next.fwd1      = s1_valid && (rd_addr1 == s1.x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      s1_valid       <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        column_counter <= column_counter_next;
        row_counter    <= row_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= s1_next;
      fwd_data <= wr_entry;
    end
  end

  // ---------------------------------------------------------------------
  // Line store: classes of rows y-1 and y-2, one entry per column
  // ---------------------------------------------------------------------
  gfcd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .we      (s1_valid),
    .waddr   (s1.x),
    .wdata   (wr_entry),
    .raddr_a (rd_addr0),
    .raddr_b (rd_addr1),
    .rdata_a (rd0),
    .rdata_b (rd1)
  );

  // ---------------------------------------------------------------------
  // Evaluation: classify the cell and decide the cell itself and up to two neighbors
  // ---------------------------------------------------------------------
  always_comb begin
    entry0 = s1.fwd0 ? fwd_data : rd0;
    entry1 = s1.fwd1 ? fwd_data : rd1;

    c.unknown = (s1.value == unknown_code);
    c.free    = !s1.value[7] && (s1.value[6:0] < free_limit);

    // Class of the cell above, which is decided now.
    self_cls = entry0.prev;

    wr_entry.prev  = c;
    wr_entry.older = self_cls;

    // Cell above: left, right, up and the new cell below.
    nb0 = c | (s1.x_ge1 ? left_cls : cls_t'('0))
            | (s1.has_right ? entry1.prev : cls_t'('0))
            | (s1.y_ge2 ? entry0.older : cls_t'('0));
    v0  = s1_valid && s1.y_ge1 && self_cls.unknown && nb0.free;

    // Last row, left neighbor of the new cell: its own left, its up and the
    // new cell on its right.
    nb1 = c | (s1.x_ge2 ? last2_c : cls_t'('0))
            | (s1.y_ge1 ? left_cls : cls_t'('0));
    v1  = s1_valid && s1.last_row && s1.x_ge1 && last_c.unknown && nb1.free;

    // Final cell of the frame: only left and up exist.
    nb2 = (s1.x_ge1 ? last_c : cls_t'('0)) | (s1.y_ge1 ? self_cls : cls_t'('0));
    v2  = s1_valid && s1.last_row && s1.last_col && c.unknown && nb2.free;

    cand[0].valid    = v0;
    cand[0].res.col  = s1.x;
    cand[0].res.row  = s1.y - ROW_W'(1);
    cand[0].res.last = !v1 && !v2;
    cand[1].valid    = v1;
    cand[1].res.col  = s1.x - COL_W'(1);
    cand[1].res.row  = s1.y;
    cand[1].res.last = !v2;
    cand[2].valid    = v2;
    cand[2].res.col  = s1.x;
    cand[2].res.row  = s1.y;
    cand[2].res.last = 1'b1;
  end

  // Hold the classes of the last two cells and of the cell above-left.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_cls <= '0;
      last_c   <= '0;
      last2_c  <= '0;
    end else if (s1_valid) begin
      left_cls <= self_cls;
      last_c   <= c;
      last2_c  <= last_c;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  gfcd_result_fifo u_result_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cand),
    .out      (frontiers),
    .has_room (has_room)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    accept && !write_enable |=> SIZE_W'(column_counter) < w_eff)
    else $error("column counter left beyond grid width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    accept && !write_enable |=> SIZE_W'(row_counter) < h_eff)
    else $error("row counter left beyond grid height");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(frontiers.valid) |-> $past(s1_valid))
    else $error("result appeared without a cell in the input register");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for grid_frontier_cell_detector: streams occupancy cells,
// predicts the frontier coordinates in-bench and checks every result transaction.
// Depends on gfcd_pkg, gfcd_cell_if, gfcd_frontier_if and the detector RTL.
module tb_top;
  import gfcd_pkg::*;

  // Widest grid the random phases use; the line fill covers these columns.
  localparam int LINE_FILL_W   = 40;
  // Cells sent into each frame of out-of-range size.
  localparam int EXTREME_CELLS = 20;

  logic                   clk;
  logic                   rst;
  logic                   write_enable;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  write_data;

  gfcd_cell_if     cells ();
  gfcd_frontier_if frontiers ();

  grid_frontier_cell_detector i_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cells        (cells),
    .frontiers    (frontiers)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the detector: configuration, line stores and position.
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] cfg_width;
  logic [SIZE_W-1:0] cfg_height;
  logic signed [7:0] cfg_unknown;
  logic [6:0]        cfg_thr;

  cls_t row_above_cls [MAX_WIDTH];      // classes of row y-1 (row y once written)
  cls_t row_two_above_cls [MAX_WIDTH];  // classes of row y-2
  cls_t left_above_cls;                 // class of row y-1 at column x-1
  int   col_pos;
  int   row_pos;

  // Frontier cells predicted but not yet seen on the output, oldest first.
  result_t expected_frontiers [$];

  int  mismatch_count;
  bit  src_idle_on;
  bit  sink_idle_on;
  int  hold_request;
  int  hold_left;

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    return (int'(v) > maxv) ? maxv : int'(v);
  endfunction

  function automatic cls_t classify_cell(input logic signed [7:0] v);
    cls_t c;
    c.unknown = (v == cfg_unknown);
    c.free    = (v >= 0) && (int'(v) < int'(cfg_thr));
    return c;
  endfunction

  function automatic void add_frontier(input int x, input int y);
    result_t r;
    r.col  = COL_W'(x);
    r.row  = ROW_W'(y);
    r.last = 1'b0;
    expected_frontiers.insert(expected_frontiers.size(), r);
  endfunction

  // Advance the shadow by one accepted cell and queue the frontiers it decides,
  // in the order the block emits them: the cell above, the left neighbor in the
  // last row, then the final cell of the frame.
  function automatic void predict_frontiers(input logic signed [7:0] v);
    int   w;
    int   h;
    int   x;
    int   y;
    int   n;
    cls_t c;
    cls_t self;
    cls_t nb;
    w = clamp_size(cfg_width, MAX_WIDTH);
    h = clamp_size(cfg_height, MAX_HEIGHT);
    // A size write may leave a counter out of range: restart it first.
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    x = col_pos;
    y = row_pos;
    n = 0;
    c = classify_cell(v);

    self = row_above_cls[x];
    if (y >= 1) begin
      nb = c;
      if (x >= 1) nb = cls_t'(nb | left_above_cls);
      if (x + 1 < w) nb = cls_t'(nb | row_above_cls[x + 1]);
      if (y >= 2) nb = cls_t'(nb | row_two_above_cls[x]);
      if (self.unknown && nb.free) begin
        add_frontier(x, y - 1);
        n++;
      end
    end
    left_above_cls       = self;
    row_two_above_cls[x] = self;
    row_above_cls[x]     = c;

    if (y == h - 1) begin
      if (x >= 1) begin
        self = row_above_cls[x - 1];
        nb = c;
        if (x >= 2) nb = cls_t'(nb | row_above_cls[x - 2]);
        if (y >= 1) nb = cls_t'(nb | row_two_above_cls[x - 1]);
        if (self.unknown && nb.free) begin
          add_frontier(x - 1, y);
          n++;
        end
      end
      if (x == w - 1) begin
        nb = '0;
        if (x >= 1) nb = cls_t'(nb | row_above_cls[x - 1]);
        if (y >= 1) nb = cls_t'(nb | row_two_above_cls[x]);
        if (c.unknown && nb.free) begin
          add_frontier(x, y);
          n++;
        end
      end
    end

    // Mark the final result of this cell.
    if (n > 0) expected_frontiers[expected_frontiers.size() - 1].last = 1'b1;

    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes at the falling edge; handshakes are judged at
  // the rising edge.
  // ---------------------------------------------------------------------------

  // Offer one cell, with random idle cycles in front, and hold it until taken.
  task automatic send_cell(input logic signed [7:0] v);
    while (src_idle_on && $urandom_range(99) < 33) begin
      cells.valid <= 1'b0;
      @(negedge clk);
    end
    cells.valid      <= 1'b1;
    cells.cell_value <= v;
    do @(posedge clk); while (!cells.ready);
    predict_frontiers(v);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted frontier has come out, then let
  // the pipeline settle so that cells with no results have left it too.
  task automatic drain_results();
    int waited;
    cells.valid <= 1'b0;
    waited = 0;
    while (expected_frontiers.size() != 0 && waited < 4000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
  endtask

  // One register write; the strobe drops in a cycle of its own so that back to
  // back writes never raise and lower it in the same step.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= data;
    @(negedge clk);
    write_enable <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_GRID_WIDTH:   cfg_width   = data;
      REG_GRID_HEIGHT:  cfg_height  = data;
      REG_UNKNOWN_CODE: cfg_unknown = data[7:0];
      REG_FREE_LIMIT:   cfg_thr     = data[6:0];
      default: ;
    endcase
  endtask

  // Write all four registers; junk in the unused upper bits must be ignored.
  task automatic set_config(input int w, input int h,
                            input logic signed [7:0] unk, input int thr);
    cfg_write(REG_GRID_WIDTH, CFG_DATA_W'(w));
    cfg_write(REG_GRID_HEIGHT, CFG_DATA_W'(h));
    cfg_write(REG_UNKNOWN_CODE, {3'($urandom), unk});
    cfg_write(REG_FREE_LIMIT, {4'($urandom), 7'(thr)});
  endtask

  // Pick a cell value: the unknown code, a free value or anything at all.
  function automatic logic signed [7:0] random_cell(input int unk_pct,
                                                     input int free_pct);
    int r;
    r = $urandom_range(99);
    if (r < unk_pct) return cfg_unknown;
    if (r < unk_pct + free_pct && cfg_thr != 0)
      return 8'($urandom_range(int'(cfg_thr) - 1, 0));
    return 8'($urandom_range(255, 0));
  endfunction

  // Receiver: a long hold-off when one is requested, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      frontiers.ready <= 1'b0;
      hold_left--;
    end else begin
      frontiers.ready <= !(sink_idle_on && $urandom_range(99) < 33);
    end
  end

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && frontiers.valid && frontiers.ready) begin
      if (expected_frontiers.size() == 0) begin
        report_mismatch($sformatf("unexpected frontier (%0d,%0d) last=%0b",
                                  frontiers.frontier_col, frontiers.frontier_row,
                                  frontiers.last_of_run));
      end else begin
        want = expected_frontiers.pop_front();
        if (frontiers.frontier_col !== want.col)
          report_mismatch($sformatf("frontier_col got %0d want %0d",
                                    frontiers.frontier_col, want.col));
        if (frontiers.frontier_row !== want.row)
          report_mismatch($sformatf("frontier_row got %0d want %0d",
                                    frontiers.frontier_row, want.row));
        if (frontiers.last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run got %0b want %0b at (%0d,%0d)",
                                    frontiers.last_of_run, want.last,
                                    want.col, want.row));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Two full rows at the widest size the random phases use. Both halves of
  // every line store entry that later tests touch then hold data, so that size
  // changes in mid-frame only ever read entries that were written.
  task automatic test_line_fill();
    set_config(LINE_FILL_W, 2, -8'sd1, 50);
    repeat (2 * LINE_FILL_W) send_cell(random_cell(45, 45));
    drain_results();
  endtask

  // Hand-built frames: field extremes, the free-threshold edge, a cell that is
  // both unknown and free, a zero threshold and a zero height.
  task automatic test_directed();
    logic signed [7:0] grid [12] = '{
      -8'sd1,  8'sd0,    -8'sd1,  8'sd127,
       8'sd49, -8'sd1,    8'sd50, -8'sd1,
      -8'sd1,  -8'sd128, -8'sd1,  8'sd0
    };
    set_config(4, 3, -8'sd1, 50);
    foreach (grid[i]) send_cell(grid[i]);
    drain_results();
    // Unknown code inside the free range: every cell is its own free neighbor,
    // and the last cell of a 2x2 frame decides three cells at once.
    set_config(2, 2, 8'sd5, 10);
    repeat (4) send_cell(8'sd5);
    drain_results();
    // Zero threshold: nothing is free. Zero height acts as a single row.
    set_config(3, 0, 8'sd0, 0);
    send_cell(8'sd0);
    send_cell(-8'sd128);
    send_cell(8'sd0);
    drain_results();
    // Height zero with real frontiers in the single row.
    set_config(5, 0, -8'sd1, 50);
    send_cell(-8'sd1);
    send_cell(8'sd0);
    send_cell(-8'sd1);
    send_cell(8'sd127);
    send_cell(-8'sd1);
    drain_results();
  endtask

  // Out-of-range sizes with extreme field values: an oversize width clamps to
  // the maximum, zero width acts as one and an oversize height clamps too. Each
  // frame stops early, so the next size write restarts the counters.
  task automatic test_size_extremes();
    set_config(2047, 1, -8'sd128, 127);
    repeat (EXTREME_CELLS) send_cell(random_cell(45, 45));
    drain_results();
    set_config(0, 2047, 8'sd127, 1);
    repeat (EXTREME_CELLS) send_cell(random_cell(50, 30));
    drain_results();
  endtask

  // Shrink the grid under the counters in mid-frame so that they restart, then
  // widen it again.
  task automatic test_counter_restart();
    set_config(8, 4, -8'sd1, 50);
    repeat (13) send_cell(random_cell(45, 45));
    drain_results();
    cfg_write(REG_GRID_WIDTH, CFG_DATA_W'(3));
    repeat (5) send_cell(random_cell(45, 45));
    drain_results();
    cfg_write(REG_GRID_HEIGHT, CFG_DATA_W'(2));
    repeat (9) send_cell(random_cell(45, 45));
    drain_results();
    cfg_write(REG_GRID_WIDTH, CFG_DATA_W'(10));
    repeat (20) send_cell(random_cell(45, 45));
    drain_results();
  endtask

  // Stall the receiver for a long stretch while cells keep coming: the result
  // queue fills and the block must stop taking cells without losing any.
  task automatic test_backpressure();
    src_idle_on = 1'b0;
    set_config(16, 1, -8'sd1, 50);
    hold_request = 300;
    for (int i = 0; i < 60; i++)
      send_cell((i % 2) ? -8'sd1 : 8'($urandom_range(49, 0)));
    drain_results();
    src_idle_on = 1'b1;
  endtask

  // Random small grids with frontier-rich content; some phases stop mid-frame
  // so that the next configuration lands on running counters.
  task automatic test_random_frames(input int n_items, input bit idle);
    int w;
    int h;
    int thr;
    int r;
    int count;
    int sent;
    logic signed [7:0] unk;
    src_idle_on  = idle;
    sink_idle_on = idle;
    sent = 0;
    while (sent < n_items) begin
      w = $urandom_range(10, 0);
      if ($urandom_range(9) == 0) w = $urandom_range(LINE_FILL_W, 11);
      h = $urandom_range(6, 0);
      r = $urandom_range(9);
      thr = (r == 0) ? 0 : (r == 1) ? 127 : $urandom_range(127, 0);
      r = $urandom_range(9);
      if (r < 4)      unk = 8'($urandom);
      else if (r < 6) unk = -8'sd1;
      else if (r < 8) unk = (thr > 0) ? 8'($urandom_range(thr - 1, 0)) : 8'($urandom);
      else if (r < 9) unk = -8'sd128;
      else            unk = 8'sd127;
      set_config(w, h, unk, thr);
      count = clamp_size(SIZE_W'(w), MAX_WIDTH) * clamp_size(SIZE_W'(h), MAX_HEIGHT);
      r = $urandom_range(3);
      if (r == 0)      count = $urandom_range(count, 1);
      else if (r == 1) count = 2 * count;
      // Keep the phase at its item budget.
      if (count > n_items - sent) count = n_items - sent;
      repeat (count) send_cell(random_cell(40, 40));
      sent += count;
      drain_results();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    write_enable     = 1'b0;
    reg_index        = '0;
    write_data       = '0;
    cells.valid      = 1'b0;
    cells.cell_value = '0;
    frontiers.ready  = 1'b0;
    mismatch_count   = 0;
    src_idle_on      = 1'b1;
    sink_idle_on     = 1'b1;
    hold_request     = 0;
    hold_left        = 0;

    // Shadow state after reset: shadow line stores set to zero, counters at origin.
    cfg_width      = GRID_WIDTH_RST;
    cfg_height     = GRID_HEIGHT_RST;
    cfg_unknown    = UNKNOWN_CODE_RST;
    cfg_thr        = FREE_LIMIT_RST;
    left_above_cls = '0;
    col_pos        = 0;
    row_pos        = 0;
    foreach (row_above_cls[i]) begin
      row_above_cls[i]     = '0;
      row_two_above_cls[i] = '0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_line_fill();
    test_directed();
    test_size_extremes();
    test_counter_restart();
    test_backpressure();
    test_random_frames(50, 1'b0);
    test_random_frames(50, 1'b1);

    drain_results();
    repeat (10) @(negedge clk);
    if (expected_frontiers.size() != 0)
      report_mismatch($sformatf("%0d predicted frontier cells never came out",
                                expected_frontiers.size()));
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #4800000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
design/gfcd_pkg.sv
design/gfcd_cell_if.sv
design/gfcd_frontier_if.sv
design/gfcd_ram.sv
design/gfcd_result_fifo.sv
design/grid_frontier_cell_detector.sv
bench/tb_top.sv
